>>> sv/rcpc_pkg.sv
// rcpc_pkg: shared constants, register indexes and types for the RC pulse capture block.
// No dependencies; used by every module in sv/.
package rcpc_pkg;

	localparam int NUM_CHANNELS = 8;
	localparam int PIN_SLOTS    = 8;
	localparam int PIN_W        = 3;
	localparam int TIME_W       = 16;
	localparam int CFG_W        = 24;
	localparam int CFG_IDX_W    = 3;
	localparam int SCALED_W     = 15;

	localparam logic [PIN_SLOTS-1:0] LIVE_MASK = PIN_SLOTS'((1 << NUM_CHANNELS) - 1);

	localparam logic [CFG_W-1:0]  CHANNEL_MAP_RST  = 24'hFAC688;
	localparam logic [PIN_SLOTS-1:0] ENABLED_RST   = 8'hF4;
	localparam logic [PIN_W-1:0]  THROTTLE_PIN_RST = 3'd4;
	localparam logic [TIME_W-1:0] MIN_WIDTH_RST    = 16'd900;
	localparam logic [TIME_W-1:0] MAX_WIDTH_RST    = 16'd2200;
	localparam logic [TIME_W-1:0] NEUTRAL_WIDTH    = 16'd1500;
	localparam logic signed [TIME_W:0] SCALE_OFFSET = 17'sd1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHANNEL_MAP  = 3'd0,
		REG_ENABLED_PINS = 3'd1,
		REG_THROTTLE_PIN = 3'd2,
		REG_MIN_WIDTH    = 3'd3,
		REG_MAX_WIDTH    = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		KIND_SAMPLE = 1'b0,
		KIND_READ   = 1'b1
	} item_kind_t;

	// common lane control for one sample word
	typedef struct packed {
		logic              sample;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] min_w;
		logic [TIME_W-1:0] max_w;
	} lane_ctl_t;

	// accepted word as seen by the merge stage
	typedef struct packed {
		logic             accept;
		item_kind_t       kind;
		logic [PIN_W-1:0] channel;
		logic             flag;
	} merge_cmd_t;

endpackage

>>> sv/rcpc_lane.sv
// rcpc_lane: one pin's capture lane, rise timestamp and bounded pulse width.
// Depends on rcpc_pkg.
module rcpc_lane (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rcpc_pkg::lane_ctl_t       ctl,
	input  logic                      active,
	input  logic                      level,
	output logic [rcpc_pkg::TIME_W-1:0] width
);
	import rcpc_pkg::*;

	logic [TIME_W-1:0] rise_q;
	logic [TIME_W-1:0] width_q;
	logic [TIME_W-1:0] delta;
	logic              in_bounds;

	assign delta     = ctl.now - rise_q;
	assign in_bounds = (ctl.min_w < delta) && (delta < ctl.max_w);
	assign width     = width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q  <= '0;
			width_q <= NEUTRAL_WIDTH;
		end else if (ctl.sample && active) begin
			if (level) begin
				rise_q <= ctl.now;
			end else if (in_bounds) begin
				width_q <= delta;
			end
		end
	end

endmodule

>>> sv/rcpc_merge.sv
// rcpc_merge: channel lookup over the lane widths, scaling, and the output word buffer.
// Depends on rcpc_pkg.
module rcpc_merge (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rcpc_pkg::merge_cmd_t                cmd,
	input  logic [rcpc_pkg::CFG_W-1:0]          channel_map,
	input  logic [rcpc_pkg::TIME_W-1:0]         widths [rcpc_pkg::PIN_SLOTS],
	output logic                                in_ready,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// signal_available[0], raw_width[16:1], scaled_value[31:17]
	output logic [31:0]                         m_axis_tdata
);
	import rcpc_pkg::*;

	logic [PIN_W-1:0]           map_a [PIN_SLOTS];
	logic [PIN_W-1:0]           pin;
	logic [TIME_W-1:0]          raw;
	logic signed [TIME_W:0]     diff;
	logic signed [TIME_W:0]     quot;
	logic [31:0]                word;
	logic                       out_valid_q;
	logic [31:0]                out_q;
	logic                       skid_valid_q;
	logic [31:0]                skid_q;

	always_comb begin
		for (int i = 0; i < PIN_SLOTS; i++) begin
			map_a[i] = channel_map[i*PIN_W +: PIN_W];
		end
	end

	assign pin  = map_a[cmd.channel];
	assign raw  = (cmd.kind == KIND_READ) ? widths[pin] : '0;
	assign diff = $signed({1'b0, raw}) - SCALE_OFFSET;
	assign quot = diff[TIME_W] ? ((diff + 17'sd3) >>> 2) : (diff >>> 2);
	assign word = (cmd.kind == KIND_READ) ? {quot[SCALED_W-1:0], raw, cmd.flag}
	                                      : {{SCALED_W{1'b0}}, {TIME_W{1'b0}}, cmd.flag};

	assign in_ready      = !skid_valid_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (m_axis_tready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= cmd.accept;
			end
		end else if (cmd.accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_axis_tready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (cmd.accept) begin
				out_q <= word;
			end
		end else if (cmd.accept) begin
			skid_q <= word;
		end
	end

endmodule

>>> sv/rc_pwm_pulse_capture.sv
// rc_pwm_pulse_capture: top level, configuration registers, edge detect, lanes and merge.
// Depends on rcpc_pkg, rcpc_lane, rcpc_merge.
//
// channel     dir  handshake                  payload
// s_axis      in   s_axis_tvalid/tready       tuser kind; tdata pin_levels, time_us, channel
// m_axis      out  m_axis_tvalid/tready       tdata signal_available, raw_width, scaled_value
// cfg         in   cfg_wen (no wait)          cfg_addr register index, cfg_wdata value
//
// One word per cycle unless s_axis_tready is low; each lane updates its state at the
// accept edge, so a word may follow in the next cycle and sees the update.
// Accepted words are registered in a two-entry output buffer (output and skid registers).
// s_axis_tready drops only while both output entries are full.
// Reset loads register defaults, widths of 1500 and zeroed rise times.
module rc_pwm_pulse_capture (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// pin_levels[7:0], time_us[23:8], channel[26:24], zero[31:27]
	input  logic [31:0]                   s_axis_tdata,
	// kind[0]
	input  logic                          s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// signal_available[0], raw_width[16:1], scaled_value[31:17]
	output logic [31:0]                   m_axis_tdata,
	input  logic                          cfg_wen,
	input  logic [rcpc_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [rcpc_pkg::CFG_W-1:0]    cfg_wdata
);
	import rcpc_pkg::*;

	logic [CFG_W-1:0]      channel_map_q;
	logic [PIN_SLOTS-1:0]  enabled_q;
	logic [PIN_W-1:0]      throttle_pin_q;
	logic [TIME_W-1:0]     min_width_q;
	logic [TIME_W-1:0]     max_width_q;
	logic [PIN_SLOTS-1:0]  last_levels_q;
	logic                  throttle_flag_q;

	logic                  accept;
	item_kind_t            kind;
	logic [PIN_SLOTS-1:0]  levels;
	logic [TIME_W-1:0]     now;
	logic [PIN_W-1:0]      channel;
	logic [PIN_SLOTS-1:0]  changed;
	logic [PIN_SLOTS-1:0]  active;
	logic                  flag_next;
	lane_ctl_t             ctl;
	merge_cmd_t            cmd;
	logic [TIME_W-1:0]     widths [PIN_SLOTS];

	assign accept  = s_axis_tvalid && s_axis_tready;
	assign kind    = item_kind_t'(s_axis_tuser);
	assign levels  = s_axis_tdata[7:0];
	assign now     = s_axis_tdata[23:8];
	assign channel = s_axis_tdata[26:24];

	assign changed = (levels ^ last_levels_q) & LIVE_MASK;
	assign active  = changed & enabled_q;

	always_comb begin
		flag_next = throttle_flag_q;
		if (kind == KIND_SAMPLE && active != '0) begin
			flag_next = changed[throttle_pin_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_map_q  <= CHANNEL_MAP_RST;
			enabled_q      <= ENABLED_RST;
			throttle_pin_q <= THROTTLE_PIN_RST;
			min_width_q    <= MIN_WIDTH_RST;
			max_width_q    <= MAX_WIDTH_RST;
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				REG_CHANNEL_MAP:  channel_map_q  <= cfg_wdata;
				REG_ENABLED_PINS: enabled_q      <= cfg_wdata[PIN_SLOTS-1:0];
				REG_THROTTLE_PIN: throttle_pin_q <= cfg_wdata[PIN_W-1:0];
				REG_MIN_WIDTH:    min_width_q    <= cfg_wdata[TIME_W-1:0];
				REG_MAX_WIDTH:    max_width_q    <= cfg_wdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_levels_q   <= '0;
			throttle_flag_q <= 1'b0;
		end else if (accept && kind == KIND_SAMPLE) begin
			last_levels_q   <= levels;
			throttle_flag_q <= flag_next;
		end
	end

	assign ctl.sample = accept && (kind == KIND_SAMPLE);
	assign ctl.now    = now;
	assign ctl.min_w  = min_width_q;
	assign ctl.max_w  = max_width_q;

	generate
		for (genvar i = 0; i < PIN_SLOTS; i++) begin : g_lane
			if (i < NUM_CHANNELS) begin : g_live
				rcpc_lane u_lane (
					.clk    (clk),
					.arst_n (arst_n),
					.ctl    (ctl),
					.active (active[i]),
					.level  (levels[i]),
					.width  (widths[i])
				);
			end else begin : g_dead
				assign widths[i] = '0;
			end
		end
	endgenerate

	assign cmd.accept  = accept;
	assign cmd.kind    = kind;
	assign cmd.channel = channel;
	assign cmd.flag    = flag_next;

	rcpc_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.channel_map   (channel_map_q),
		.widths        (widths),
		.in_ready      (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with empty output");

	a_read_keeps_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == KIND_READ) |=> $stable(throttle_flag_q))
		else $error("read word changed throttle flag");

	a_quiet_sample_keeps_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == KIND_SAMPLE && active == '0) |=> $stable(throttle_flag_q))
		else $error("flag changed without an enabled pin edge");
`endif

endmodule
